// ===== sv/adc_round_robin_capture_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// adc round-robin capture monitor assertion macros
// property check helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ADC_ROUND_ROBIN_CAPTURE_MONITOR_ASSERT_SVH
`define ADC_ROUND_ROBIN_CAPTURE_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define ARRC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("arrc assertion failed");
`define ARRC_ASSERT_NOW(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("arrc assertion failed");
`else
`define ARRC_ASSERT(lbl, clk, rst, prop)
`define ARRC_ASSERT_NOW(lbl, clk, prop)
`endif

`endif

// ===== sv/arrc_pkg.sv =====
// ----------------------------------------------------------------------------
// arrc_pkg
// shared widths, codes and interface structs of the capture monitor
// ----------------------------------------------------------------------------
package arrc_pkg;

  localparam int RAW_W    = 16;
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int IDX_W    = 10;
  localparam int SEL_W    = 3;
  localparam int CH_IDX_W = 4;
  localparam int CH_SPAN  = 2 ** CH_IDX_W;
  localparam int MASK_W   = 8;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [PADDR_W-3:0] REG_CHANNEL_MASK = '0;
  localparam logic [TIME_W-1:0]  TIME_ALL_ONES    = '1;

  typedef enum logic [2:0] {
    OP_CONVERT      = 3'd0,
    OP_ARM          = 3'd1,
    OP_READ_LATEST  = 3'd2,
    OP_READ_CAPTURE = 3'd3,
    OP_CLEAR        = 3'd4
  } op_t;

  typedef struct packed {
    logic                convert;
    logic                arm;
    logic [CH_IDX_W-1:0] ch;
    logic [SEL_W-1:0]    sel;
    logic [COUNT_W-1:0]  length;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now;
  } cap_cmd_t;

  typedef struct packed {
    logic               active;
    logic [COUNT_W-1:0] taken;
    logic [TIME_W-1:0]  span;
  } cap_stat_t;

  typedef struct packed {
    logic              convert;
    logic              clear;
    logic              fresh;
    logic [TIME_W-1:0] now;
  } stat_cmd_t;

endpackage

// ===== sv/adc_round_robin_capture_monitor.sv =====
// ----------------------------------------------------------------------------
// adc_round_robin_capture_monitor
// round-robin adc sample store with single-channel capture and run statistics
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled and returns one result per item:
// an input register holds the item, decode, channel rotation and statistics
// update follow, and the result register presents read_value and error while
// the status outputs show the state after that item. The capture store is a
// single memory with one write and one read port; its read is issued as the
// item is accepted. The store has no clearing pass, so the block is ready
// straight out of reset. The user must write channel_mask through the register
// port only while no item is in flight; the block does not enforce it.
`include "adc_round_robin_capture_monitor_assert.svh"

module adc_round_robin_capture_monitor #(
  parameter int CHANNELS      = 8,
  parameter int CAPTURE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arrc_pkg::PADDR_W-1:0]  paddr,
  input  logic [arrc_pkg::PDATA_W-1:0]  pwdata,
  output logic [arrc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    operation,
  input  logic [arrc_pkg::RAW_W-1:0]    raw_sample,
  input  logic                          new_run,
  input  logic [arrc_pkg::TIME_W-1:0]   timestamp_us,
  input  logic [arrc_pkg::SEL_W-1:0]    channel_select,
  input  logic [arrc_pkg::COUNT_W-1:0]  capture_length,
  input  logic [arrc_pkg::IDX_W-1:0]    read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [arrc_pkg::SAMPLE_W-1:0] read_value,
  output logic                          error,
  output logic                          capture_active,
  output logic [arrc_pkg::COUNT_W-1:0]  captured_count,
  output logic [arrc_pkg::TIME_W-1:0]   capture_span_us,
  output logic [arrc_pkg::TIME_W-1:0]   conversion_count,
  output logic [arrc_pkg::TIME_W-1:0]   overrun_count,
  output logic [arrc_pkg::TIME_W-1:0]   max_gap_us,
  output logic [arrc_pkg::TIME_W-1:0]   min_gap_us,
  output logic [arrc_pkg::SEL_W-1:0]    current_channel
);
  import arrc_pkg::*;

  localparam int CW = $clog2(CHANNELS);

  // configuration
  logic [MASK_W-1:0]   channel_mask;
  logic [CH_SPAN-1:0]  mask_wide;
  logic [CHANNELS-1:0] en_bits;
  logic [CH_SPAN-1:0]  en_wide;
  logic [CH_SPAN-1:0]  new_wide;
  logic [CHANNELS-1:0] new_en;
  logic                mask_wr;
  logic [CW-1:0]       lowest;

  // channel rotation and latest samples
  logic [CW-1:0]       rr_ptr;
  logic [CW-1:0]       follow;
  logic [CH_IDX_W-1:0] nc_wide;
  logic [SAMPLE_W-1:0] latest [CHANNELS];

  // item pipeline
  logic                out_ready;
  logic                in_take;
  logic                s1_adv;
  logic                s1_valid;
  logic [2:0]          s1_op;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_fresh;
  logic [TIME_W-1:0]   s1_now;
  logic [SEL_W-1:0]    s1_sel;
  logic [COUNT_W-1:0]  s1_len;
  logic [IDX_W-1:0]    s1_idx;

  logic                ch_ok;
  logic                len_ok;
  logic [SAMPLE_W-1:0] res_value;
  logic                res_error;
  logic [SAMPLE_W-1:0] cap_rd_data;
  cap_cmd_t            cap_cmd;
  cap_stat_t           cap_stat;
  stat_cmd_t           stat_cmd;

  // register port
  assign pready  = 1'b1;
  assign mask_wr = psel && penable && pwrite &&
                   (paddr[PADDR_W-1:2] == REG_CHANNEL_MASK);
  assign prdata  = (paddr[PADDR_W-1:2] == REG_CHANNEL_MASK) ? PDATA_W'(channel_mask) : '0;

  assign mask_wide = CH_SPAN'(channel_mask);
  assign en_bits   = mask_wide[CHANNELS-1:0];
  assign en_wide   = CH_SPAN'(en_bits);
  assign new_wide  = CH_SPAN'(pwdata[MASK_W-1:0]);
  assign new_en    = new_wide[CHANNELS-1:0];

  always_comb begin
    lowest = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (new_en[i]) begin
        lowest = CW'(i);
      end
    end
  end

  // next enabled channel after the current one, wrapping
  always_comb begin
    logic [CW:0] cand;
    follow = rr_ptr;
    for (int k = CHANNELS - 1; k >= 1; k--) begin
      cand = {1'b0, rr_ptr} + (CW + 1)'(k);
      if (cand >= (CW + 1)'(CHANNELS)) begin
        cand = cand - (CW + 1)'(CHANNELS);
      end
      if (en_bits[cand[CW-1:0]]) begin
        follow = cand[CW-1:0];
      end
    end
  end

  // handshake
  assign out_ready = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op     <= operation;
      s1_sample <= raw_sample[SAMPLE_W-1:0];
      s1_fresh  <= new_run;
      s1_now    <= timestamp_us;
      s1_sel    <= channel_select;
      s1_len    <= capture_length;
      s1_idx    <= read_index;
    end
  end

  // item decode
  assign ch_ok  = en_wide[CH_IDX_W'(s1_sel)];
  assign len_ok = (s1_len != '0) && (32'(s1_len) <= 32'(CAPTURE_DEPTH));

  always_comb begin
    res_value = '0;
    res_error = 1'b0;
    unique case (s1_op)
      OP_CONVERT: begin
      end
      OP_ARM: begin
        res_error = !ch_ok || !len_ok;
      end
      OP_READ_LATEST: begin
        res_error = !ch_ok;
        if (ch_ok) begin
          res_value = latest[CW'(s1_sel)];
        end
      end
      OP_READ_CAPTURE: begin
        res_error = cap_stat.active || (COUNT_W'(s1_idx) >= cap_stat.taken);
        if (!res_error) begin
          res_value = cap_rd_data;
        end
      end
      OP_CLEAR: begin
      end
      default: begin
        res_error = 1'b1;
      end
    endcase
  end

  assign cap_cmd.convert = s1_adv && (s1_op == OP_CONVERT);
  assign cap_cmd.arm     = s1_adv && (s1_op == OP_ARM) && ch_ok && len_ok;
  assign cap_cmd.ch      = CH_IDX_W'(rr_ptr);
  assign cap_cmd.sel     = s1_sel;
  assign cap_cmd.length  = s1_len;
  assign cap_cmd.sample  = s1_sample;
  assign cap_cmd.now     = s1_now;

  assign stat_cmd.convert = s1_adv && (s1_op == OP_CONVERT);
  assign stat_cmd.clear   = s1_adv && (s1_op == OP_CLEAR);
  assign stat_cmd.fresh   = s1_fresh;
  assign stat_cmd.now     = s1_now;

  // mask, rotation and latest samples
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask <= '0;
      rr_ptr       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        latest[i] <= '0;
      end
    end else if (mask_wr) begin
      channel_mask <= pwdata[MASK_W-1:0];
      rr_ptr       <= lowest;
    end else if (cap_cmd.convert) begin
      latest[rr_ptr] <= s1_sample;
      rr_ptr         <= follow;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_value <= res_value;
      error      <= res_error;
    end
  end

  arrc_capture #(
    .CAPTURE_DEPTH(CAPTURE_DEPTH)
  ) u_capture (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cap_cmd),
    .rd_en   (in_take),
    .rd_index(read_index),
    .rd_data (cap_rd_data),
    .stat    (cap_stat)
  );

  arrc_stats u_stats (
    .clk             (clk),
    .rst             (rst),
    .cmd             (stat_cmd),
    .conversion_count(conversion_count),
    .overrun_count   (overrun_count),
    .max_gap_us      (max_gap_us),
    .min_gap_us      (min_gap_us)
  );

  assign capture_active  = cap_stat.active;
  assign captured_count  = cap_stat.taken;
  assign capture_span_us = cap_stat.span;
  assign nc_wide         = CH_IDX_W'(rr_ptr);
  assign current_channel = nc_wide[SEL_W-1:0];

  `ARRC_ASSERT(a_next_enabled, clk, rst, (en_bits != '0) |-> en_bits[rr_ptr])
  `ARRC_ASSERT(a_result_follows, clk, rst, s1_adv |=> out_valid)
  `ARRC_ASSERT_NOW(a_reset_empties, clk, rst |=> (!out_valid && !s1_valid))

endmodule

// ===== sv/arrc_capture.sv =====
// ----------------------------------------------------------------------------
// arrc_capture
// single-channel capture control and capture sample memory
// ----------------------------------------------------------------------------
`include "adc_round_robin_capture_monitor_assert.svh"

module arrc_capture #(
  parameter int CAPTURE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  arrc_pkg::cap_cmd_t            cmd,
  input  logic                          rd_en,
  input  logic [arrc_pkg::IDX_W-1:0]    rd_index,
  output logic [arrc_pkg::SAMPLE_W-1:0] rd_data,
  output arrc_pkg::cap_stat_t           stat
);
  import arrc_pkg::*;

  localparam int AW = $clog2(CAPTURE_DEPTH);

  logic [COUNT_W-1:0]  wanted;
  logic [COUNT_W-1:0]  taken;
  logic [COUNT_W-1:0]  taken_inc;
  logic [SEL_W-1:0]    channel;
  logic [TIME_W-1:0]   first_time;
  logic [TIME_W-1:0]   span;
  logic                hit;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] mem [CAPTURE_DEPTH];

  assign taken_inc = taken + COUNT_W'(1);
  assign hit = cmd.convert && (wanted != '0) && (CH_IDX_W'(channel) == cmd.ch) &&
               (taken < wanted);
  assign wr_addr = AW'(taken);
  assign rd_addr = AW'(rd_index);

  always_ff @(posedge clk) begin
    if (hit) begin
      mem[wr_addr] <= cmd.sample;
    end
    if (rd_en) begin
      if (hit && (wr_addr == rd_addr)) begin
        rd_data <= cmd.sample;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted     <= '0;
      taken      <= '0;
      channel    <= '0;
      first_time <= '0;
      span       <= '0;
    end else if (cmd.arm) begin
      wanted     <= cmd.length;
      taken      <= '0;
      channel    <= cmd.sel;
      first_time <= '0;
      span       <= '0;
    end else if (hit) begin
      if (taken == '0) begin
        first_time <= cmd.now;
        span       <= '0;
      end else begin
        span <= cmd.now - first_time;
      end
      taken <= taken_inc;
      if (taken_inc >= wanted) begin
        wanted <= '0;
      end
    end
  end

  assign stat.active = (wanted != '0);
  assign stat.taken  = taken;
  assign stat.span   = span;

  `ARRC_ASSERT(a_cap_taken_bound, clk, rst, stat.active |-> (taken < wanted))
  `ARRC_ASSERT(a_cap_done, clk, rst, (hit && (taken_inc == wanted)) |=> !stat.active)

endmodule

// ===== sv/arrc_stats.sv =====
// ----------------------------------------------------------------------------
// arrc_stats
// conversion and overrun counters, run-start gap extremes
// ----------------------------------------------------------------------------
`include "adc_round_robin_capture_monitor_assert.svh"

module arrc_stats (
  input  logic                        clk,
  input  logic                        rst,
  input  arrc_pkg::stat_cmd_t         cmd,
  output logic [arrc_pkg::TIME_W-1:0] conversion_count,
  output logic [arrc_pkg::TIME_W-1:0] overrun_count,
  output logic [arrc_pkg::TIME_W-1:0] max_gap_us,
  output logic [arrc_pkg::TIME_W-1:0] min_gap_us
);
  import arrc_pkg::*;

  logic [TIME_W-1:0] conversions;
  logic [TIME_W-1:0] overruns;
  logic [1:0]        run_count;
  logic [1:0]        run_eff;
  logic [TIME_W-1:0] last_run;
  logic [TIME_W-1:0] worst;
  logic [TIME_W-1:0] best;
  logic [TIME_W-1:0] gap;
  logic              measure;
  logic              ovr_step;

  assign gap      = cmd.now - last_run;
  assign measure  = cmd.fresh && (last_run != '0);
  assign run_eff  = cmd.fresh ? 2'd0 : run_count;
  assign ovr_step = cmd.convert && !cmd.fresh && (run_count == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      conversions <= '0;
      overruns    <= '0;
      run_count   <= '0;
      last_run    <= '0;
      worst       <= '0;
      best        <= TIME_ALL_ONES;
    end else if (cmd.clear) begin
      overruns <= '0;
      worst    <= '0;
      best     <= TIME_ALL_ONES;
    end else if (cmd.convert) begin
      conversions <= conversions + TIME_W'(1);
      if (cmd.fresh) begin
        last_run <= cmd.now;
      end
      if (measure && (gap > worst)) begin
        worst <= gap;
      end
      if (measure && (gap < best)) begin
        best <= gap;
      end
      if (run_eff != 2'd2) begin
        run_count <= run_eff + 2'd1;
      end else begin
        run_count <= run_eff;
      end
      if (run_eff == 2'd1) begin
        overruns <= overruns + TIME_W'(1);
      end
    end
  end

  assign conversion_count = conversions;
  assign overrun_count    = overruns;
  assign max_gap_us       = worst;
  assign min_gap_us       = (best == TIME_ALL_ONES) ? '0 : best;

  `ARRC_ASSERT(a_gap_order, clk, rst, (best != TIME_ALL_ONES) |-> (worst >= best))
  `ARRC_ASSERT(a_overrun_step, clk, rst, ovr_step |=> (overruns == $past(overruns) + TIME_W'(1)))

endmodule
